// ===== design/sacl_pkg.sv =====
package sacl_pkg;

    // Geometry (SETS is a power of two: the set index is the low line bits)
    localparam int ADDR_W           = 64;
    localparam int LINE_OFFSET_BITS = 6;
    localparam int SETS             = 64;
    localparam int WAYS             = 8;
    localparam int SET_W            = $clog2(SETS);
    localparam int WAY_W            = $clog2(WAYS);
    localparam int LINE_W           = ADDR_W - LINE_OFFSET_BITS;
    localparam int TAG_W            = LINE_W - SET_W;
    localparam int STAMP_W          = 64;
    localparam int CNT_W            = 64;

    // Result fields
    localparam int WAY_OUT_W  = 3;
    localparam int OUT_USER_W = 2;
    localparam int OUT_RAW_W  = WAY_OUT_W + 2 * CNT_W;
    localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - OUT_RAW_W;

    // One way of a set row: valid in the lowest bit, then tag, then stamp
    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic [TAG_W-1:0]   tag;
        logic               valid;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);
    localparam int ROW_W   = WAYS * ENTRY_W;

    typedef entry_t [WAYS-1:0] row_t;

    // Outcome of the way scan
    typedef struct packed {
        logic             hit;
        logic [WAY_W-1:0] way;
    } scan_res_t;

endpackage

// ===== design/sacl_ram.sv =====
module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/sacl_way_scan.sv =====
module sacl_way_scan
    import sacl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             step,
    input  logic [WAY_W-1:0] way_idx,
    input  entry_t           entry,
    input  logic [TAG_W-1:0] ref_tag,
    output scan_res_t        res
);

    logic               hit_reg;
    logic               inv_reg;
    logic [WAY_W-1:0]   hit_way_reg;
    logic [WAY_W-1:0]   inv_way_reg;
    logic [WAY_W-1:0]   old_way_reg;
    logic [STAMP_W-1:0] old_stamp_reg;

    logic tag_match;
    logic older;

    assign tag_match = entry.valid && (entry.tag == ref_tag);
    assign older     = (way_idx == '0) || (entry.stamp < old_stamp_reg);

    // Found flags, cleared when a new lookup starts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
            inv_reg <= 1'b0;
        end
        else if (start)
        begin
            hit_reg <= 1'b0;
            inv_reg <= 1'b0;
        end
        else if (step)
        begin
            if (tag_match)
            begin
                hit_reg <= 1'b1;
            end
            if (!entry.valid)
            begin
                inv_reg <= 1'b1;
            end
        end
    end

    // Way trackers: matching way, first invalid way, oldest stamp
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            if (tag_match && !hit_reg)
            begin
                hit_way_reg <= way_idx;
            end
            if (!entry.valid && !inv_reg)
            begin
                inv_way_reg <= way_idx;
            end
            if (older)
            begin
                old_stamp_reg <= entry.stamp;
                old_way_reg   <= way_idx;
            end
        end
    end

    assign res.hit = hit_reg;
    assign res.way = hit_reg ? hit_way_reg : (inv_reg ? inv_way_reg : old_way_reg);

endmodule

// ===== design/set_assoc_lru_cache_tag_model_unit.sv =====
// Set-associative cache tag model with LRU replacement.
// Input stream: one beat per access, s_axis_tdata carries the 64-bit byte address.
// Output stream: one beat per access with hit/filtered flags in m_axis_tuser and
// the way, running access count and running hit count in m_axis_tdata.
// Tags, valid bits and last-use stamps of a whole set live in one row of a
// synchronous RAM (one row per set, registered read).
// Flow: an access that hits the same-line filter skips the way scan and goes
// from accept straight to the finish state. Any other access is scanned: the set
// row is read at accept, then one way per cycle is checked for tag match,
// first invalid way and oldest stamp, then the updated row is written back
// as the result is loaded. The next beat is accepted once the block is idle.
// Reset: all control state clears, then a clearing pass writes every set row
// to zero; s_axis_tready stays low during the pass.
// Stall: the result sits in an output register; if it has not been taken when
// the next result is ready, the block holds that result until the register
// frees up.
module set_assoc_lru_cache_tag_model_unit
    import sacl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [ADDR_W-1:0]     s_axis_tdata,   // address
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // way, access_count, hit_count, zero pad
    output logic [OUT_USER_W-1:0] m_axis_tuser    // hit, filtered
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    logic [1:0]          state_reg;
    logic [SET_W-1:0]    clr_cnt_reg;
    logic [WAY_W-1:0]    way_cnt_reg;
    logic [LINE_W-1:0]   line_reg;
    logic                filt_reg;
    logic [LINE_W-1:0]   recent_line_reg;
    logic                recent_valid_reg;
    logic [CNT_W-1:0]    acc_cnt_reg;
    logic [CNT_W-1:0]    hit_cnt_reg;
    logic                out_valid_reg;
    logic                out_hit_reg;
    logic                out_filt_reg;
    logic [WAY_OUT_W-1:0] out_way_reg;
    logic [CNT_W-1:0]    out_acc_reg;
    logic [CNT_W-1:0]    out_hitc_reg;

    logic              in_accept;
    logic [LINE_W-1:0] in_line;
    logic              filter_hit;
    logic              out_free;
    logic              fin_go;
    logic              hit_flag;
    logic [CNT_W-1:0]  acc_next;
    logic [CNT_W-1:0]  hit_next;
    logic [ROW_W-1:0]  rd_data;
    row_t              row_rd;
    row_t              row_wr;
    entry_t            new_entry;
    scan_res_t         scan_res;
    logic              ram_wr_en;
    logic [SET_W-1:0]  ram_wr_addr;
    logic [ROW_W-1:0]  ram_wr_data;

    // Handshake and filter check
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_line       = s_axis_tdata[ADDR_W-1:LINE_OFFSET_BITS];
    assign filter_hit    = recent_valid_reg && (recent_line_reg == in_line);
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign fin_go        = (state_reg == ST_FIN) && out_free;

    // Counter updates for the finishing access
    assign hit_flag = filt_reg || scan_res.hit;
    assign acc_next = acc_cnt_reg + CNT_W'(1);
    assign hit_next = hit_cnt_reg + CNT_W'(hit_flag);

    // Row modify: the hit or victim way takes the tag and a fresh stamp
    assign row_rd          = row_t'(rd_data);
    assign new_entry.stamp = acc_next;
    assign new_entry.tag   = line_reg[LINE_W-1:SET_W];
    assign new_entry.valid = 1'b1;

    always_comb
    begin
        row_wr               = row_rd;
        row_wr[scan_res.way] = new_entry;
    end

    // Write port: clearing pass or write-back
    assign ram_wr_en   = (state_reg == ST_CLEAR) || (fin_go && !filt_reg);
    assign ram_wr_addr = (state_reg == ST_CLEAR) ? clr_cnt_reg : line_reg[SET_W-1:0];
    assign ram_wr_data = (state_reg == ST_CLEAR) ? '0 : ROW_W'(row_wr);

    sacl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_set_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (in_accept),
        .rd_addr (in_line[SET_W-1:0]),
        .rd_data (rd_data)
    );

    sacl_way_scan u_way_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (in_accept),
        .step    (state_reg == ST_SCAN),
        .way_idx (way_cnt_reg),
        .entry   (row_rd[way_cnt_reg]),
        .ref_tag (line_reg[LINE_W-1:SET_W]),
        .res     (scan_res)
    );

    // Sequencer and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_cnt_reg      <= '0;
            way_cnt_reg      <= '0;
            filt_reg         <= 1'b0;
            recent_line_reg  <= '0;
            recent_valid_reg <= 1'b0;
            acc_cnt_reg      <= '0;
            hit_cnt_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + SET_W'(1);
                    if (clr_cnt_reg == SET_W'(SETS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        if (filter_hit)
                        begin
                            filt_reg  <= 1'b1;
                            state_reg <= ST_FIN;
                        end
                        else
                        begin
                            filt_reg         <= 1'b0;
                            recent_line_reg  <= in_line;
                            recent_valid_reg <= 1'b1;
                            way_cnt_reg      <= '0;
                            state_reg        <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    way_cnt_reg <= way_cnt_reg + WAY_W'(1);
                    if (way_cnt_reg == WAY_W'(WAYS - 1))
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        acc_cnt_reg <= acc_next;
                        hit_cnt_reg <= hit_next;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_CLEAR;
                end
            endcase

            // Output register occupancy
            if (fin_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Address capture and result payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            line_reg <= in_line;
        end
        if (fin_go)
        begin
            out_hit_reg  <= hit_flag;
            out_filt_reg <= filt_reg;
            out_way_reg  <= filt_reg ? '0 : WAY_OUT_W'(scan_res.way);
            out_acc_reg  <= acc_next;
            out_hitc_reg <= hit_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_hitc_reg, out_acc_reg, out_way_reg};
    assign m_axis_tuser  = {out_filt_reg, out_hit_reg};

endmodule

// ===== verif/set_assoc_lru_cache_tag_model_checker.sv =====
module set_assoc_lru_cache_tag_model_checker
    import sacl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [ADDR_W-1:0]     s_axis_tdata,   // address
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,   // way, access_count, hit_count, zero pad
    input  logic [OUT_USER_W-1:0] m_axis_tuser,   // hit, filtered
    output int                    outstanding,
    output int                    fail_count
);

    localparam int ACC_LSB  = WAY_OUT_W;
    localparam int HITS_LSB = WAY_OUT_W + CNT_W;

    typedef struct packed {
        logic                 hit;
        logic                 filtered;
        logic [WAY_OUT_W-1:0] way;
        logic [CNT_W-1:0]     accesses;
        logic [CNT_W-1:0]     hits;
    } lookup_t;

    // Shadow copy of the tag array
    logic [TAG_W-1:0]   tags   [SETS][WAYS];
    logic               valids [SETS][WAYS];
    logic [STAMP_W-1:0] stamps [SETS][WAYS];
    logic [CNT_W-1:0]   access_total;
    logic [CNT_W-1:0]   hit_total;
    logic [LINE_W-1:0]  prev_line;
    logic               prev_line_valid;

    lookup_t lookup_q [$];
    lookup_t want;
    lookup_t got;

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    // One access against the shadow array: filter, set lookup, then fill
    function automatic lookup_t look_up_line(input logic [ADDR_W-1:0] addr);
        logic [LINE_W-1:0]  line;
        logic [SET_W-1:0]   set_idx;
        logic [TAG_W-1:0]   line_tag;
        logic [STAMP_W-1:0] oldest;
        int                 victim;
        lookup_t            res;
        line     = addr[ADDR_W-1:LINE_OFFSET_BITS];
        set_idx  = line[SET_W-1:0];
        line_tag = line[LINE_W-1:SET_W];
        access_total = access_total + CNT_W'(1);
        res = '0;
        res.accesses = access_total;

        // same line as the previous miss-path access
        if (prev_line_valid && prev_line == line)
        begin
            hit_total    = hit_total + CNT_W'(1);
            res.hit      = 1'b1;
            res.filtered = 1'b1;
            res.hits     = hit_total;
            return res;
        end
        prev_line       = line;
        prev_line_valid = 1'b1;

        for (int w = 0; w < WAYS; w++)
        begin
            if (valids[set_idx][w] && tags[set_idx][w] == line_tag)
            begin
                stamps[set_idx][w] = access_total;
                hit_total = hit_total + CNT_W'(1);
                res.hit   = 1'b1;
                res.way   = WAY_OUT_W'(w);
                res.hits  = hit_total;
                return res;
            end
        end

        // miss: first empty way, else oldest stamp (lowest way on ties)
        victim = -1;
        for (int w = 0; w < WAYS; w++)
        begin
            if (victim < 0 && !valids[set_idx][w])
            begin
                victim = w;
            end
        end
        if (victim < 0)
        begin
            victim = 0;
            oldest = stamps[set_idx][0];
            for (int w = 1; w < WAYS; w++)
            begin
                if (stamps[set_idx][w] < oldest)
                begin
                    oldest = stamps[set_idx][w];
                    victim = w;
                end
            end
        end
        tags[set_idx][victim]   = line_tag;
        valids[set_idx][victim] = 1'b1;
        stamps[set_idx][victim] = access_total;
        res.way  = WAY_OUT_W'(victim);
        res.hits = hit_total;
        return res;
    endfunction

    // Watch both channels; results are compared before new accesses are queued
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SETS; s++)
            begin
                for (int w = 0; w < WAYS; w++)
                begin
                    valids[s][w] = 1'b0;
                    stamps[s][w] = '0;
                end
            end
            access_total    = '0;
            hit_total       = '0;
            prev_line       = '0;
            prev_line_valid = 1'b0;
            lookup_q.delete();
            outstanding     = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.hit      = m_axis_tuser[0];
                got.filtered = m_axis_tuser[1];
                got.way      = m_axis_tdata[WAY_OUT_W-1:0];
                got.accesses = m_axis_tdata[ACC_LSB +: CNT_W];
                got.hits     = m_axis_tdata[HITS_LSB +: CNT_W];
                if (lookup_q.size() == 0)
                begin
                    report_mismatch("result beat with no access pending");
                end
                else
                begin
                    want = lookup_q.pop_front();
                    if (got.hit !== want.hit)
                        report_mismatch($sformatf("hit %0b, expected %0b", got.hit, want.hit));
                    if (got.filtered !== want.filtered)
                        report_mismatch($sformatf("filtered %0b, expected %0b",
                                                  got.filtered, want.filtered));
                    if (got.way !== want.way)
                        report_mismatch($sformatf("way %0d, expected %0d", got.way, want.way));
                    if (got.accesses !== want.accesses)
                        report_mismatch($sformatf("access_count %0d, expected %0d",
                                                  got.accesses, want.accesses));
                    if (got.hits !== want.hits)
                        report_mismatch($sformatf("hit_count %0d, expected %0d",
                                                  got.hits, want.hits));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                lookup_q.push_back(look_up_line(s_axis_tdata));
            end
            outstanding = lookup_q.size();
        end
    end

endmodule

// ===== verif/tb_set_assoc_lru_cache_tag_model_unit.sv =====
module tb_set_assoc_lru_cache_tag_model_unit;
    import sacl_pkg::*;

    localparam int POOL_N    = 12;
    localparam int PHASE_LEN = 560;
    localparam int HOLD_LEN  = 400;

    logic                  clk;
    logic                  rst_n          = 1'b0;
    logic                  s_axis_tvalid  = 1'b0;
    logic                  s_axis_tready;
    logic [ADDR_W-1:0]     s_axis_tdata   = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;

    int outstanding;
    int fail_count;

    int   send_idle_pct = 32;
    int   recv_idle_pct = 77;
    logic hold_go       = 1'b0;
    logic recv_hold     = 1'b0;

    logic [TAG_W-1:0]  tag_pool [POOL_N];
    logic [ADDR_W-1:0] last_addr = '0;

    set_assoc_lru_cache_tag_model_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    set_assoc_lru_cache_tag_model_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .outstanding   (outstanding),
        .fail_count    (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop well past the slowest legal run
    initial
    begin
        #8000000;
        $display("Some tests failed");
        $finish;
    end

    // Result side: random backpressure, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        wait (hold_go);
        @(posedge clk);
        recv_hold <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        recv_hold <= 1'b0;
    end

    function automatic logic [ADDR_W-1:0] make_addr(input logic [TAG_W-1:0] line_tag,
                                                    input logic [SET_W-1:0] set_idx,
                                                    input logic [LINE_OFFSET_BITS-1:0] offs);
        return {line_tag, set_idx, offs};
    endfunction

    // Offer one access beat, with random gaps ahead of it
    task automatic send_access(input logic [ADDR_W-1:0] addr);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= addr;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        last_addr = addr;
    endtask

    // Stop offering and wait for every pending result
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
    endtask

    // Mostly a small tag pool over a few sets so lines hit, fill and evict;
    // the rest repeats the last line or is a fully random address
    task automatic run_accesses(input int count, input int hold_at);
        logic [ADDR_W-1:0] addr;
        logic [SET_W-1:0]  set_idx;
        int                pick;
        for (int i = 0; i < count; i++)
        begin
            if (i == hold_at)
                hold_go <= 1'b1;
            pick = $urandom_range(99);
            if (pick < 15)
            begin
                addr = {last_addr[ADDR_W-1:LINE_OFFSET_BITS], LINE_OFFSET_BITS'($urandom)};
            end
            else if (pick < 25)
            begin
                addr = {$urandom, $urandom};
            end
            else
            begin
                set_idx = ($urandom_range(9) == 0) ? SET_W'($urandom)
                                                   : SET_W'($urandom_range(3));
                addr = make_addr(tag_pool[$urandom_range(POOL_N-1)], set_idx,
                                 LINE_OFFSET_BITS'($urandom));
            end
            send_access(addr);
        end
    endtask

    initial
    begin
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        for (int i = 2; i < POOL_N; i++)
        begin
            tag_pool[i] = TAG_W'({$urandom, $urandom});
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // line 0 first must miss (filter starts empty), then filter hits
        send_access('0);
        send_access('0);
        send_access(ADDR_W'(2**LINE_OFFSET_BITS - 1));
        send_access(ADDR_W'(2**LINE_OFFSET_BITS));
        send_access('1);
        // back to line 0 through the set lookup
        send_access('0);
        // fill all ways of one set, then refresh way 0 and force evictions
        for (int k = 1; k <= WAYS; k++)
        begin
            send_access(make_addr(TAG_W'(k) | (TAG_W'(k[0]) << (TAG_W-1)), SET_W'(5),
                                  LINE_OFFSET_BITS'(k)));
        end
        send_access(make_addr(TAG_W'(1) | (TAG_W'(1) << (TAG_W-1)), SET_W'(5), '0));
        send_access(make_addr(TAG_W'(WAYS + 1), SET_W'(5), '1));
        send_access(make_addr(TAG_W'(2), SET_W'(5), '0));
        send_access(make_addr('1, SET_W'(5), '0));
        drain_results();

        send_idle_pct = 32;
        recv_idle_pct = 77;
        run_accesses(PHASE_LEN, -1);
        drain_results();

        send_idle_pct = 77;
        recv_idle_pct = 32;
        run_accesses(PHASE_LEN, -1);
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_accesses(PHASE_LEN, 100);
        drain_results();

        repeat (20) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/sacl_pkg.sv
design/sacl_ram.sv
design/sacl_way_scan.sv
design/set_assoc_lru_cache_tag_model_unit.sv
verif/set_assoc_lru_cache_tag_model_checker.sv
verif/tb_set_assoc_lru_cache_tag_model_unit.sv
